// ===== rtl/jsu_pkg.sv =====
// Shared types, character constants and hex decode for the JSON string unescape decoder.
`default_nettype none
package jsu_pkg;

  localparam int unsigned MAX_OUT = 6;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    str_end;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_decoder_core.sv =====
// Top level of the JSON string unescape decoder.
// Accepts one escaped byte per transaction (tlast on the final byte of a string) and sends
// the unescaped bytes. The front end takes a byte every cycle while the job queue
// (QDEPTH entries) has room; each byte becomes one job of 0 to 6 output bytes. The emitter
// sends one output byte per cycle while out_tready is high, so a byte that produces n
// outputs takes n output transactions; ordinary bytes and single-byte escapes sustain one
// byte per cycle under that condition, and a backslash or partial \u sequence produces no
// output until it resolves. Each job passes through the registered job queue.
`default_nettype none
module json_string_unescape_decoder_core #(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // string_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] run_last
  output logic            out_tlast   // string_end
);

  jsu_pkg::job_t    push_job, head;
  jsu_pkg::q_stat_t q_stat;
  logic             push, pop;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  jsu_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Front end: accepts raw bytes, tracks escape state and builds at most one output job per byte.
`default_nettype none
module jsu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic             in_tlast,
  input  wire jsu_pkg::q_stat_t q_stat,
  output logic                  push,
  output jsu_pkg::job_t         job
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_U    = 3'd2;
  localparam logic [2:0] PH_D1   = 3'd3;
  localparam logic [2:0] PH_D2   = 3'd4;
  localparam logic [2:0] PH_D3   = 3'd5;

  logic [2:0]      phase_r, phase_nxt;
  logic [11:0]     hex_r, hex_nxt;
  logic [2:0][7:0] held_r, held_nxt;
  jsu_pkg::hex_t   hv;
  logic [1:0]      held;
  logic [2:0]      pos;
  logic            take;

  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign push      = take && (job.cnt != 3'd0);

  always_comb begin
    phase_nxt    = phase_r;
    hex_nxt      = hex_r;
    held_nxt     = held_r;
    hv           = jsu_pkg::hex_value(in_tdata);
    held         = 2'(phase_r - PH_U);
    pos          = {1'b0, held} + 3'd2;
    job          = '0;
    job.bytes[0] = jsu_pkg::CH_BSL;
    job.bytes[1] = jsu_pkg::CH_U;
    job.bytes[2] = held_r[0];
    job.bytes[3] = held_r[1];
    job.bytes[4] = held_r[2];
    job.str_end  = in_tlast;
    unique case (phase_r) inside
      PH_ESC: begin
        phase_nxt = PH_IDLE;
        job.cnt   = 3'd1;
        unique case (in_tdata)
          jsu_pkg::CH_QUOTE: job.bytes[0] = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSL:   job.bytes[0] = jsu_pkg::CH_BSL;
          jsu_pkg::CH_N:     job.bytes[0] = jsu_pkg::CH_LF;
          jsu_pkg::CH_R:     job.bytes[0] = jsu_pkg::CH_CR;
          jsu_pkg::CH_T:     job.bytes[0] = jsu_pkg::CH_TAB;
          jsu_pkg::CH_U: begin
            if (in_tlast) begin
              job.cnt = 3'd2;
            end else begin
              job.cnt   = 3'd0;
              phase_nxt = PH_U;
              hex_nxt   = '0;
            end
          end
          default: begin
            job.bytes[1] = in_tdata;
            job.cnt      = 3'd2;
          end
        endcase
      end
      PH_U, PH_D1, PH_D2, PH_D3: begin
        if (!hv.ok) begin
          if (in_tdata == jsu_pkg::CH_BSL && !in_tlast) begin
            phase_nxt = PH_ESC;
            job.cnt   = pos;
          end else begin
            phase_nxt      = PH_IDLE;
            job.bytes[pos] = in_tdata;
            job.cnt        = pos + 3'd1;
          end
        end else if (phase_r == PH_D3) begin
          phase_nxt = PH_IDLE;
          if (hex_r[11:4] == 8'd0) begin
            job.bytes[0] = {hex_r[3:0], hv.val};
            job.cnt      = 3'd1;
          end else begin
            job.bytes[5] = in_tdata;
            job.cnt      = 3'd6;
          end
        end else if (in_tlast) begin
          phase_nxt      = PH_IDLE;
          job.bytes[pos] = in_tdata;
          job.cnt        = pos + 3'd1;
        end else begin
          held_nxt[held] = in_tdata;
          hex_nxt        = {hex_r[7:0], hv.val};
          phase_nxt      = phase_r + 3'd1;
        end
      end
      default: begin
        if (in_tdata == jsu_pkg::CH_BSL && !in_tlast) begin
          phase_nxt = PH_ESC;
        end else begin
          phase_nxt    = PH_IDLE;
          job.bytes[0] = in_tdata;
          job.cnt      = 3'd1;
        end
      end
    endcase
    if (in_tlast) begin
      phase_nxt = PH_IDLE;
      hex_nxt   = '0;
      held_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hex_r   <= '0;
      held_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_queue.sv =====
// Job queue between front end and emitter.
`default_nettype none
module jsu_queue #(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire jsu_pkg::job_t push_job,
  input  wire logic          pop,
  output jsu_pkg::job_t      head,
  output jsu_pkg::q_stat_t   q_stat
);

  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  jsu_pkg::job_t mem [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign q_stat.empty = (count_r == CW'(0));
  assign q_stat.full  = (count_r == CW'(QDEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Emitter: walks the head job and sends its bytes one per transaction.
`default_nettype none
module jsu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jsu_pkg::job_t    head,
  input  wire jsu_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  logic [2:0] idx_r, idx_nxt;
  logic       fire;

  assign out_tvalid = !q_stat.empty;
  assign out_tdata  = head.bytes[idx_r];
  assign out_tuser  = (idx_r == head.cnt - 3'd1);
  assign out_tlast  = out_tuser && head.str_end;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tuser;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_tuser ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_checker.sv =====
// Port-level checks for the JSON string unescape decoder, bound to the top level.
`default_nettype none
module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("string end not on last byte of a run");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

endmodule

bind json_string_unescape_decoder_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
